>>> sv/mrc3d_pkg.sv
// Shared types and constants of the 3D mask resel counter.
`default_nettype none
package mrc3d_pkg;

	localparam int CNT_W     = 25;
	localparam int FRAC_BITS = 16;
	localparam int EUL_W     = 27;
	localparam int RES_W     = 46;
	localparam int INV_W     = 18;
	localparam int SIZE_W    = 9;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 18;
	localparam int S_TDATA_W = 8;
	localparam int M_FIELD_W = EUL_W + 3 * RES_W + CNT_W;
	localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
	localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

	localparam logic [CFG_IDX_W-1:0] REG_X_SIZE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_SIZE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_FWHM_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_FWHM_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_FWHM_Z = 3'd4;

	typedef struct packed {
		logic [CNT_W-1:0] p;
		logic [CNT_W-1:0] ex;
		logic [CNT_W-1:0] ey;
		logic [CNT_W-1:0] ez;
		logic [CNT_W-1:0] fxy;
		logic [CNT_W-1:0] fxz;
		logic [CNT_W-1:0] fyz;
		logic [CNT_W-1:0] c;
	} counts_t;

	typedef struct packed {
		logic    start;
		counts_t counts;
		logic    too_deep;
	} fin_req_t;

	typedef struct packed {
		logic [INV_W-1:0] rx;
		logic [INV_W-1:0] ry;
		logic [INV_W-1:0] rz;
	} fwhm_t;

	typedef struct packed {
		logic             too_deep;
		logic [CNT_W-1:0] inside_count;
		logic [RES_W-1:0] resel_three;
		logic [RES_W-1:0] resel_two;
		logic [RES_W-1:0] resel_one;
		logic [EUL_W-1:0] euler_term;
	} result_t;

endpackage
`default_nettype wire

>>> sv/mrc3d_resel.sv
// End-of-volume arithmetic: Euler term and resel volumes with a shared shift-add multiplier.
`default_nettype none
module mrc3d_resel (
	input  logic                clk,
	input  logic                arst_n,
	input  mrc3d_pkg::fin_req_t req,
	input  mrc3d_pkg::fwhm_t    fwhm,
	output logic                idle,
	output logic                res_valid,
	input  logic                res_ready,
	output mrc3d_pkg::result_t  res
);

	localparam int AW    = 80;
	localparam int OW    = 28;
	localparam int EW    = mrc3d_pkg::EUL_W + 2;
	localparam int OP_W  = 4;
	localparam int BIT_W = $clog2(mrc3d_pkg::INV_W);
	localparam int RW    = mrc3d_pkg::RES_W;
	localparam int F     = mrc3d_pkg::FRAC_BITS;

	localparam logic [OP_W-1:0]  OP_R1_END  = 4'd3;
	localparam logic [OP_W-1:0]  OP_TMP_END = 4'd5;
	localparam logic [OP_W-1:0]  OP_R2_END  = 4'd8;
	localparam logic [OP_W-1:0]  OP_COUNT   = 4'd11;
	localparam logic [BIT_W-1:0] BIT_LAST   = BIT_W'(mrc3d_pkg::INV_W - 1);
	localparam logic [AW-1:0]    HALF2      = AW'(1) << (F - 1);
	localparam logic [AW-1:0]    HALF3      = AW'(1) << (2 * F - 1);
	localparam logic [RW-1:0]    RES_MAX    = {1'b0, {(RW-1){1'b1}}};
	localparam logic [RW-1:0]    RES_MIN    = {1'b1, {(RW-1){1'b0}}};
	localparam logic [mrc3d_pkg::EUL_W-1:0] EUL_MAX = {1'b0, {(mrc3d_pkg::EUL_W-1){1'b1}}};
	localparam logic [mrc3d_pkg::EUL_W-1:0] EUL_MIN = {1'b1, {(mrc3d_pkg::EUL_W-1){1'b0}}};

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_PREP = 5'b00010,
		ST_LOAD = 5'b00100,
		ST_RUN  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	typedef enum logic [2:0] {A_A1, A_A2, A_A3, A_DXY, A_DXZ, A_DYZ, A_C, A_ACC} asel_t;
	typedef enum logic [1:0] {B_RX, B_RY, B_RZ} bsel_t;
	typedef enum logic [1:0] {I_ZERO, I_KEEP, I_TMP} isel_t;

	typedef struct packed {
		asel_t a;
		bsel_t b;
		isel_t i;
	} op_t;

	// Operation list: r1 = a1 rx + a2 ry + a3 rz; then dyz ry rz is parked in tmp;
	// r2 = (dxy ry + dxz rz) rx + tmp; r3 = ((c rx) ry) rz.
	function automatic op_t op_entry(input logic [OP_W-1:0] k);
		op_t o;
		begin
			unique case (k)
				4'd0:    o = '{a: A_A1,  b: B_RX, i: I_ZERO};
				4'd1:    o = '{a: A_A2,  b: B_RY, i: I_KEEP};
				4'd2:    o = '{a: A_A3,  b: B_RZ, i: I_KEEP};
				4'd3:    o = '{a: A_DYZ, b: B_RY, i: I_ZERO};
				4'd4:    o = '{a: A_ACC, b: B_RZ, i: I_ZERO};
				4'd5:    o = '{a: A_DXY, b: B_RY, i: I_ZERO};
				4'd6:    o = '{a: A_DXZ, b: B_RZ, i: I_KEEP};
				4'd7:    o = '{a: A_ACC, b: B_RX, i: I_TMP};
				4'd8:    o = '{a: A_C,   b: B_RX, i: I_ZERO};
				4'd9:    o = '{a: A_ACC, b: B_RY, i: I_ZERO};
				4'd10:   o = '{a: A_ACC, b: B_RZ, i: I_ZERO};
				default: o = '{a: A_C,   b: B_RX, i: I_ZERO};
			endcase
			return o;
		end
	endfunction

	function automatic logic [AW-1:0] sext_op(input logic [OW-1:0] v);
		return {{(AW-OW){v[OW-1]}}, v};
	endfunction

	function automatic logic [RW-1:0] sat_res(input logic [AW-1:0] v);
		logic fits;
		begin
			fits = (v[AW-1:RW-1] == '0) || (v[AW-1:RW-1] == '1);
			if (fits)
				return v[RW-1:0];
			return v[AW-1] ? RES_MIN : RES_MAX;
		end
	endfunction

	state_t                    state_q;
	logic [OP_W-1:0]           op_q;
	logic [BIT_W-1:0]          bit_q;
	logic                      res_valid_q;
	logic [AW-1:0]             m_q;
	logic [mrc3d_pkg::INV_W-1:0] b_q;
	logic [AW-1:0]             acc_q;
	logic [AW-1:0]             tmp_q;
	mrc3d_pkg::counts_t        cnt_q;
	logic                      deep_q;
	logic [mrc3d_pkg::EUL_W-1:0] eu_q;
	logic [RW-1:0]             r1_q;
	logic [RW-1:0]             r2_q;
	logic [RW-1:0]             r3_q;
	mrc3d_pkg::result_t        res_q;

	op_t                       op;
	logic [OW-1:0]             a1, a2, a3, dxy, dxz, dyz;
	logic [AW-1:0]             a_val;
	logic [mrc3d_pkg::INV_W-1:0] b_val;
	logic [AW-1:0]             init_val;
	logic [EW-1:0]             eu_sum;
	logic [mrc3d_pkg::EUL_W-1:0] eu_sat;
	logic [AW-1:0]             s2, sh2, s3;
	logic [AW-2*F-1:0]         q3;
	logic [RW-1:0]             r3_val;
	logic                      out_load;

	assign a1  = OW'(cnt_q.ex) - OW'(cnt_q.fxy) - OW'(cnt_q.fxz) + OW'(cnt_q.c);
	assign a2  = OW'(cnt_q.ey) - OW'(cnt_q.fxy) - OW'(cnt_q.fyz) + OW'(cnt_q.c);
	assign a3  = OW'(cnt_q.ez) - OW'(cnt_q.fxz) - OW'(cnt_q.fyz) + OW'(cnt_q.c);
	assign dxy = OW'(cnt_q.fxy) - OW'(cnt_q.c);
	assign dxz = OW'(cnt_q.fxz) - OW'(cnt_q.c);
	assign dyz = OW'(cnt_q.fyz) - OW'(cnt_q.c);

	assign eu_sum = EW'(cnt_q.p) - EW'(cnt_q.ex) - EW'(cnt_q.ey) - EW'(cnt_q.ez)
		+ EW'(cnt_q.fxy) + EW'(cnt_q.fxz) + EW'(cnt_q.fyz) - EW'(cnt_q.c);

	always_comb begin
		if ((eu_sum[EW-1:mrc3d_pkg::EUL_W-1] == '0) || (eu_sum[EW-1:mrc3d_pkg::EUL_W-1] == '1))
			eu_sat = eu_sum[mrc3d_pkg::EUL_W-1:0];
		else
			eu_sat = eu_sum[EW-1] ? EUL_MIN : EUL_MAX;
	end

	// Round half up, then arithmetic shift down to the output fraction.
	assign s2  = acc_q + HALF2;
	assign sh2 = {{F{s2[AW-1]}}, s2[AW-1:F]};
	// The triple product is never negative.
	assign s3  = acc_q + HALF3;
	assign q3  = s3[AW-1:2*F];
	assign r3_val = (q3[AW-2*F-1:RW-1] != '0) ? RES_MAX : q3[RW-1:0];

	always_comb begin
		op = op_entry(op_q);
		unique case (op.a)
			A_A1:  a_val = sext_op(a1);
			A_A2:  a_val = sext_op(a2);
			A_A3:  a_val = sext_op(a3);
			A_DXY: a_val = sext_op(dxy);
			A_DXZ: a_val = sext_op(dxz);
			A_DYZ: a_val = sext_op(dyz);
			A_C:   a_val = AW'(cnt_q.c);
			A_ACC: a_val = acc_q;
		endcase
		unique case (op.b)
			B_RX:    b_val = fwhm.rx;
			B_RY:    b_val = fwhm.ry;
			B_RZ:    b_val = fwhm.rz;
			default: b_val = fwhm.rx;
		endcase
		unique case (op.i)
			I_ZERO:  init_val = '0;
			I_KEEP:  init_val = acc_q;
			I_TMP:   init_val = tmp_q;
			default: init_val = '0;
		endcase
	end

	assign out_load = (state_q == ST_DONE) && (!res_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= '0;
			bit_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.start)
						state_q <= ST_PREP;
				end
				ST_PREP: begin
					op_q    <= '0;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (op_q == OP_COUNT) begin
						state_q <= ST_DONE;
					end else begin
						bit_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					bit_q <= bit_q + BIT_W'(1);
					if (bit_q == BIT_LAST) begin
						op_q    <= op_q + OP_W'(1);
						state_q <= ST_LOAD;
					end
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (out_load)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && req.start) begin
			cnt_q  <= req.counts;
			deep_q <= req.too_deep;
		end
		if (state_q == ST_PREP)
			eu_q <= eu_sat;
		if (state_q == ST_LOAD) begin
			if (op_q == OP_R1_END)
				r1_q <= sat_res(acc_q);
			if (op_q == OP_TMP_END)
				tmp_q <= acc_q;
			if (op_q == OP_R2_END)
				r2_q <= sat_res(sh2);
			if (op_q == OP_COUNT)
				r3_q <= r3_val;
			m_q   <= a_val;
			b_q   <= b_val;
			acc_q <= init_val;
		end
		if (state_q == ST_RUN) begin
			if (b_q[0])
				acc_q <= acc_q + m_q;
			m_q <= m_q << 1;
			b_q <= b_q >> 1;
		end
		if (out_load) begin
			res_q.euler_term   <= eu_q;
			res_q.resel_one    <= r1_q;
			res_q.resel_two    <= r2_q;
			res_q.resel_three  <= r3_q;
			res_q.inside_count <= cnt_q.p;
			res_q.too_deep     <= deep_q;
		end
	end

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> (state_q == ST_IDLE))
		else $error("finisher started while busy");

	a_r3_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RUN) && (op_q >= OP_R2_END)) |-> !acc_q[AW-1])
		else $error("triple product went negative");

	a_op_range: assert property (@(posedge clk) disable iff (!arst_n)
		op_q <= OP_COUNT)
		else $error("operation index beyond list");

endmodule
`default_nettype wire

>>> sv/mask_resel_count_3d_core.sv
// Top level of the streaming 3D mask resel counter.
// A new voxel is not accepted until the previous one has finished the read-modify-write of the
// plane history memory (registered read, then write back).
// When a volume ends, the shared shift-add multiplier runs 11 passes, and input stalls during them.
// Reset clears positions, feature counts and control state at once; the history memory is not
// cleared and needs no clearing pass. Registers reset to sizes 1 and reciprocal FWHM 1.0.
`default_nettype none
module mask_resel_count_3d_core #(
	parameter int MAX_X = 256,
	parameter int MAX_Y = 256,
	parameter int MAX_Z = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [mrc3d_pkg::S_TDATA_W-1:0]       s_axis_tdata,  // [0] voxel
	input  logic                                  s_axis_tlast,  // last_voxel
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// euler_term, resel_one, resel_two, resel_three, inside_count, zero fill (lowest first)
	output logic [mrc3d_pkg::M_TDATA_W-1:0]       m_axis_tdata,
	output logic                                  m_axis_tuser,  // too_deep
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mrc3d_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mrc3d_pkg::CFG_DAT_W-1:0]       cfg_data
);

	localparam int XW     = $clog2(MAX_X);
	localparam int YW     = $clog2(MAX_Y);
	localparam int ZW     = $clog2(MAX_Z + 1);
	localparam int HAW    = XW + YW;
	localparam int HDEPTH = 1 << HAW;
	localparam int XSW    = (XW + 1 > mrc3d_pkg::SIZE_W) ? XW + 1 : mrc3d_pkg::SIZE_W;
	localparam int YSW    = (YW + 1 > mrc3d_pkg::SIZE_W) ? YW + 1 : mrc3d_pkg::SIZE_W;
	localparam int CW     = mrc3d_pkg::CNT_W;
	localparam int NF     = 8;

	localparam int F_P   = 0;
	localparam int F_EX  = 1;
	localparam int F_EY  = 2;
	localparam int F_EZ  = 3;
	localparam int F_FXY = 4;
	localparam int F_FXZ = 5;
	localparam int F_FYZ = 6;
	localparam int F_C   = 7;

	localparam logic [CW-1:0] CNT_MAX = '1;

	logic [mrc3d_pkg::SIZE_W-1:0] x_size_q, y_size_q;
	logic [mrc3d_pkg::INV_W-1:0]  inv_x_q, inv_y_q, inv_z_q;

	logic              busy_q;
	logic              v_s1, last_s1;
	logic [1:0]        rd0_s1, rd1_s1;
	logic [XW-1:0]     pos_x_q;
	logic [YW-1:0]     pos_y_q;
	logic [ZW-1:0]     pos_z_q;
	logic              plane_q;
	logic              deep_q;
	logic [CW-1:0]     cnt_q [NF];
	logic              prv_v_q, prv_n010_q, prv_n001_q, prv_n011_q;

	// Each entry holds the voxel at (y, x) of both plane buffers, one bit per plane.
	logic [1:0]        hist_mem [HDEPTH];

	logic [HAW-1:0]    rd_addr0, rd_addr1;
	logic [1:0]        wr_word;
	logic [XSW-1:0]    xs_ext, xs;
	logic [YSW-1:0]    ys_ext, ys;
	logic              x_wrap, y_wrap;
	logic              hx, hy, hz;
	logic              r001, r010, r011;
	logic              n100, n010, n110, n001, n101, n011, n111;
	logic [NF-1:0]     inc;
	logic [CW-1:0]     cnt_next [NF];
	logic              deep_next;
	logic              accept;
	logic              fin_idle;
	mrc3d_pkg::fin_req_t fin_req;
	mrc3d_pkg::fwhm_t    fwhm;
	mrc3d_pkg::result_t  res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_size_q <= mrc3d_pkg::SIZE_W'(1);
			y_size_q <= mrc3d_pkg::SIZE_W'(1);
			inv_x_q  <= mrc3d_pkg::INV_W'(1) << mrc3d_pkg::FRAC_BITS;
			inv_y_q  <= mrc3d_pkg::INV_W'(1) << mrc3d_pkg::FRAC_BITS;
			inv_z_q  <= mrc3d_pkg::INV_W'(1) << mrc3d_pkg::FRAC_BITS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mrc3d_pkg::REG_X_SIZE:     x_size_q <= cfg_data[mrc3d_pkg::SIZE_W-1:0];
				mrc3d_pkg::REG_Y_SIZE:     y_size_q <= cfg_data[mrc3d_pkg::SIZE_W-1:0];
				mrc3d_pkg::REG_INV_FWHM_X: inv_x_q  <= cfg_data[mrc3d_pkg::INV_W-1:0];
				mrc3d_pkg::REG_INV_FWHM_Y: inv_y_q  <= cfg_data[mrc3d_pkg::INV_W-1:0];
				mrc3d_pkg::REG_INV_FWHM_Z: inv_z_q  <= cfg_data[mrc3d_pkg::INV_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready = !busy_q && fin_idle;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign rd_addr0 = {pos_y_q, pos_x_q};
	assign rd_addr1 = {pos_y_q - YW'(1), pos_x_q};

	always_ff @(posedge clk) begin
		if (busy_q)
			hist_mem[rd_addr0] <= wr_word;
		rd0_s1 <= hist_mem[rd_addr0];
		rd1_s1 <= hist_mem[rd_addr1];
	end

	// Size zero acts as one; sizes above the buffer limit act as the limit.
	always_comb begin
		xs_ext = XSW'(x_size_q);
		ys_ext = YSW'(y_size_q);
		if (x_size_q == '0)
			xs = XSW'(1);
		else if (xs_ext > XSW'(MAX_X))
			xs = XSW'(MAX_X);
		else
			xs = xs_ext;
		if (y_size_q == '0)
			ys = YSW'(1);
		else if (ys_ext > YSW'(MAX_Y))
			ys = YSW'(MAX_Y);
		else
			ys = ys_ext;
	end

	assign x_wrap = (XSW'(pos_x_q) + XSW'(1)) >= xs;
	assign y_wrap = (YSW'(pos_y_q) + YSW'(1)) >= ys;

	assign hx = (pos_x_q != '0);
	assign hy = (pos_y_q != '0);
	assign hz = (pos_z_q != '0);

	// The x-1 neighbors were read for the previous voxel of the same row and are kept in the
	// prv registers, so two memory reads cover all seven neighbors.
	assign r001 = rd0_s1[!plane_q];
	assign r010 = rd1_s1[plane_q];
	assign r011 = rd1_s1[!plane_q];

	assign n100 = hx & prv_v_q;
	assign n010 = hy & r010;
	assign n110 = hx & hy & prv_n010_q;
	assign n001 = hz & r001;
	assign n101 = hz & hx & prv_n001_q;
	assign n011 = hz & hy & r011;
	assign n111 = hz & hx & hy & prv_n011_q;

	assign wr_word = plane_q ? {v_s1, r001} : {r001, v_s1};

	always_comb begin
		inc[F_P]   = v_s1;
		inc[F_EX]  = v_s1 & n100;
		inc[F_EY]  = v_s1 & n010;
		inc[F_EZ]  = v_s1 & n001;
		inc[F_FXY] = v_s1 & n100 & n010 & n110;
		inc[F_FXZ] = v_s1 & n100 & n001 & n101;
		inc[F_FYZ] = v_s1 & n010 & n001 & n011;
		inc[F_C]   = v_s1 & n100 & n010 & n110 & n001 & n101 & n011 & n111;
		for (int i = 0; i < NF; i++) begin
			if (inc[i] && (cnt_q[i] != CNT_MAX))
				cnt_next[i] = cnt_q[i] + CW'(1);
			else
				cnt_next[i] = cnt_q[i];
		end
	end

	assign deep_next = deep_q | (pos_z_q >= ZW'(MAX_Z));

	always_comb begin
		fin_req.start      = busy_q && last_s1;
		fin_req.too_deep   = deep_next;
		fin_req.counts.p   = cnt_next[F_P];
		fin_req.counts.ex  = cnt_next[F_EX];
		fin_req.counts.ey  = cnt_next[F_EY];
		fin_req.counts.ez  = cnt_next[F_EZ];
		fin_req.counts.fxy = cnt_next[F_FXY];
		fin_req.counts.fxz = cnt_next[F_FXZ];
		fin_req.counts.fyz = cnt_next[F_FYZ];
		fin_req.counts.c   = cnt_next[F_C];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
			plane_q <= 1'b0;
			deep_q  <= 1'b0;
			for (int i = 0; i < NF; i++)
				cnt_q[i] <= '0;
		end else if (busy_q) begin
			busy_q <= 1'b0;
			if (last_s1) begin
				pos_x_q <= '0;
				pos_y_q <= '0;
				pos_z_q <= '0;
				plane_q <= 1'b0;
				deep_q  <= 1'b0;
				for (int i = 0; i < NF; i++)
					cnt_q[i] <= '0;
			end else begin
				deep_q <= deep_next;
				for (int i = 0; i < NF; i++)
					cnt_q[i] <= cnt_next[i];
				if (!x_wrap) begin
					pos_x_q <= pos_x_q + XW'(1);
				end else begin
					pos_x_q <= '0;
					if (!y_wrap) begin
						pos_y_q <= pos_y_q + YW'(1);
					end else begin
						pos_y_q <= '0;
						plane_q <= !plane_q;
						if (pos_z_q < ZW'(MAX_Z))
							pos_z_q <= pos_z_q + ZW'(1);
					end
				end
			end
		end else if (accept) begin
			busy_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			v_s1    <= s_axis_tdata[0];
			last_s1 <= s_axis_tlast;
		end
		if (busy_q) begin
			prv_v_q    <= v_s1;
			prv_n010_q <= r010;
			prv_n001_q <= r001;
			prv_n011_q <= r011;
		end
	end

	assign fwhm.rx = inv_x_q;
	assign fwhm.ry = inv_y_q;
	assign fwhm.rz = inv_z_q;

	mrc3d_resel u_resel (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (fin_req),
		.fwhm      (fwhm),
		.idle      (fin_idle),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {{mrc3d_pkg::M_PAD_W{1'b0}}, res.inside_count, res.resel_three,
		res.resel_two, res.resel_one, res.euler_term};
	assign m_axis_tuser = res.too_deep;

	a_rmw_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("voxel transaction accepted during read-modify-write");

	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && last_s1) |-> fin_idle)
		else $error("volume ended while finisher busy");

	a_cnt_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[F_C] <= cnt_q[F_FXY]) && (cnt_q[F_FXY] <= cnt_q[F_EX])
		&& (cnt_q[F_EX] <= cnt_q[F_P]))
		else $error("feature counts out of order");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pos_z_q <= ZW'(MAX_Z))
		else $error("plane index beyond limit");

endmodule
`default_nettype wire
